// ===== rtl/ulpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ulpc_pkg
// Shared types, constants and helpers for the UTF-8 letter palindrome checker.
// ----------------------------------------------------------------------------
package ulpc_pkg;

	localparam int MAX_LETTERS_DEF = 1024;
	localparam int LETTER_W        = 11;
	localparam int CP_W            = 21;

	// Cyrillic and Latin range bounds, the Yo pair and the case delta
	localparam logic [CP_W-1:0] CYR_FIRST   = 21'h000410;
	localparam logic [CP_W-1:0] CYR_UPPER_Z = 21'h00042F;
	localparam logic [CP_W-1:0] CYR_LAST    = 21'h00044F;
	localparam logic [CP_W-1:0] CYR_YO_UP   = 21'h000401;
	localparam logic [CP_W-1:0] CYR_YO_LO   = 21'h000451;
	localparam logic [CP_W-1:0] LAT_UP_A    = 21'h000041;
	localparam logic [CP_W-1:0] LAT_UP_Z    = 21'h00005A;
	localparam logic [CP_W-1:0] LAT_LO_A    = 21'h000061;
	localparam logic [CP_W-1:0] LAT_LO_Z    = 21'h00007A;
	localparam logic [CP_W-1:0] CASE_DELTA  = 21'h000020;

	// UTF-8 prefix codes
	localparam logic [1:0] CONT_TAG  = 2'b10;
	localparam logic [2:0] LEAD2_TAG = 3'b110;
	localparam logic [3:0] LEAD3_TAG = 4'b1110;
	localparam logic [4:0] LEAD4_TAG = 5'b11110;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_DONE
	} ulpc_state_t;

	typedef struct packed {
		logic                valid;
		logic [LETTER_W-1:0] code;
	} letter_t;

	function automatic logic is_letter(input logic [CP_W-1:0] cp);
		is_letter = (cp inside {[LAT_UP_A:LAT_UP_Z], [LAT_LO_A:LAT_LO_Z],
			[CYR_FIRST:CYR_LAST], CYR_YO_UP, CYR_YO_LO});
	endfunction

	function automatic logic [LETTER_W-1:0] fold(input logic [CP_W-1:0] cp);
		logic [CP_W-1:0] r;
		if (cp inside {[LAT_UP_A:LAT_UP_Z], [CYR_FIRST:CYR_UPPER_Z]}) begin
			r = cp + CASE_DELTA;
		end else if (cp == CYR_YO_UP) begin
			r = CYR_YO_LO;
		end else begin
			r = cp;
		end
		fold = r[LETTER_W-1:0];
	endfunction

endpackage

// ===== rtl/ulpc_ram.sv =====
// ----------------------------------------------------------------------------
// ulpc_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module ulpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

// ===== rtl/ulpc_decode.sv =====
// ----------------------------------------------------------------------------
// ulpc_decode
// UTF-8 byte decoder with letter filter and case fold.
// ----------------------------------------------------------------------------
module ulpc_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        text_byte,
	input  logic              end_of_line,
	output ulpc_pkg::letter_t letter
);

	logic [ulpc_pkg::CP_W-1:0] part_q;
	logic [ulpc_pkg::CP_W-1:0] part_d;
	logic [1:0]                cont_q;
	logic [1:0]                cont_d;
	logic [ulpc_pkg::CP_W-1:0] shifted;
	logic [ulpc_pkg::CP_W-1:0] cp;
	logic                      cp_vld;
	logic                      handled;

	assign shifted = {part_q[ulpc_pkg::CP_W-7:0], text_byte[5:0]};

	always_comb begin
		part_d  = part_q;
		cont_d  = cont_q;
		cp      = '0;
		cp_vld  = 1'b0;
		handled = 1'b0;
		if (cont_q != 2'd0) begin
			if (text_byte[7:6] == ulpc_pkg::CONT_TAG) begin
				handled = 1'b1;
				cont_d  = cont_q - 2'd1;
				if (cont_q == 2'd1) begin
					cp     = shifted;
					cp_vld = 1'b1;
					part_d = '0;
				end else begin
					part_d = shifted;
				end
			end else begin
				// broken sequence: drop it, re-examine this byte as a lead
				cont_d = 2'd0;
				part_d = '0;
			end
		end
		if (!handled) begin
			if (!text_byte[7]) begin
				cp     = {{(ulpc_pkg::CP_W-8){1'b0}}, text_byte};
				cp_vld = 1'b1;
			end else if (text_byte[7:5] == ulpc_pkg::LEAD2_TAG) begin
				part_d = {{(ulpc_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
				cont_d = 2'd1;
			end else if (text_byte[7:4] == ulpc_pkg::LEAD3_TAG) begin
				part_d = {{(ulpc_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
				cont_d = 2'd2;
			end else if (text_byte[7:3] == ulpc_pkg::LEAD4_TAG) begin
				part_d = {{(ulpc_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
				cont_d = 2'd3;
			end
		end
		if (end_of_line) begin
			// an open sequence at line end is dropped
			part_d = '0;
			cont_d = 2'd0;
		end
	end

	assign letter.valid = take && cp_vld && ulpc_pkg::is_letter(cp);
	assign letter.code  = ulpc_pkg::fold(cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q <= '0;
			cont_q <= 2'd0;
		end else if (take) begin
			part_q <= part_d;
			cont_q <= cont_d;
		end
	end

endmodule

// ===== rtl/utf8_letter_palindrome_check.sv =====
// ----------------------------------------------------------------------------
// utf8_letter_palindrome_check
// Per-byte UTF-8 decode into a letter store, then a palindrome walk per line.
// ----------------------------------------------------------------------------
// Bytes other than the last of a line: one per cycle, busy stays low.
// Last byte: the walk compares up to P = floor(n/2) letter pairs, fewer on an
// early mismatch and none if n < 2 or on overflow, then done pulses. The
// walk reads both ends through the store's two read ports and one shared
// comparator, a READ state then a CMP state per pair. No result backpressure.
// Reset (arst_n low) clears control state; the letter store is not cleared.
// ----------------------------------------------------------------------------
module utf8_letter_palindrome_check #(
	parameter int MAX_LETTERS = ulpc_pkg::MAX_LETTERS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] text_byte,
	input  logic       end_of_line,
	output logic       done,
	output logic       is_palindrome,
	output logic       store_overflow
);

	localparam int AW = $clog2(MAX_LETTERS);
	localparam int CW = $clog2(MAX_LETTERS + 1);

	ulpc_pkg::ulpc_state_t state_q, state_d;

	logic                          take;
	ulpc_pkg::letter_t             letter;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 count_nx;
	logic                          ovf_q;
	logic                          ovf_nx;
	logic                          store_full;
	logic                          wr_en;
	logic [AW-1:0]                 lo_q;
	logic [AW-1:0]                 hi_q;
	logic [CW-1:0]                 left_q;
	logic                          pal_q;
	logic                          res_ovf_q;
	logic                          rd_en;
	logic                          pair_ne;
	logic [ulpc_pkg::LETTER_W-1:0] rd_lo;
	logic [ulpc_pkg::LETTER_W-1:0] rd_hi;

	// request accepted only while idle
	assign take = start && !busy;

	ulpc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.text_byte   (text_byte),
		.end_of_line (end_of_line),
		.letter      (letter)
	);

	// Store is full once count reaches capacity; extra letters only flag overflow.
	assign store_full = (count_q == CW'(MAX_LETTERS));
	assign wr_en      = letter.valid && !store_full;
	assign count_nx   = wr_en ? count_q + CW'(1) : count_q;
	assign ovf_nx     = ovf_q || (letter.valid && store_full);

	ulpc_ram #(
		.WIDTH (ulpc_pkg::LETTER_W),
		.DEPTH (MAX_LETTERS)
	) u_store (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (count_q[AW-1:0]),
		.wr_data   (letter.code),
		.rd_en     (rd_en),
		.rd_addr_a (lo_q),
		.rd_addr_b (hi_q),
		.rd_data_a (rd_lo),
		.rd_data_b (rd_hi)
	);

	// shared comparator for the walk
	assign pair_ne = (rd_lo != rd_hi);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ulpc_pkg::ST_IDLE: begin
				if (take && end_of_line) begin
					if (ovf_nx || (count_nx < CW'(2))) begin
						state_d = ulpc_pkg::ST_DONE;
					end else begin
						state_d = ulpc_pkg::ST_READ;
					end
				end
			end
			ulpc_pkg::ST_READ: begin
				state_d = ulpc_pkg::ST_CMP;
			end
			ulpc_pkg::ST_CMP: begin
				if (pair_ne || (left_q == CW'(1))) begin
					state_d = ulpc_pkg::ST_DONE;
				end else begin
					state_d = ulpc_pkg::ST_READ;
				end
			end
			ulpc_pkg::ST_DONE: begin
				state_d = ulpc_pkg::ST_IDLE;
			end
			default: begin
				state_d = ulpc_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		busy  = 1'b1;
		done  = 1'b0;
		rd_en = 1'b0;
		case (state_q)
			ulpc_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			ulpc_pkg::ST_READ: begin
				rd_en = 1'b1;
			end
			ulpc_pkg::ST_CMP: begin
			end
			ulpc_pkg::ST_DONE: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign is_palindrome  = pal_q;
	assign store_overflow = res_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ulpc_pkg::ST_IDLE;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				if (end_of_line) begin
					// line closes: clear for the next one
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else begin
					count_q <= count_nx;
					ovf_q   <= ovf_nx;
				end
			end
		end
	end

	// walk registers: pair indexes, pairs left, running verdict
	always_ff @(posedge clk) begin
		if (take && end_of_line) begin
			lo_q      <= '0;
			hi_q      <= AW'(count_nx - CW'(1));
			left_q    <= count_nx >> 1;
			pal_q     <= !ovf_nx;
			res_ovf_q <= ovf_nx;
		end else if (state_q == ulpc_pkg::ST_CMP) begin
			if (pair_ne) begin
				pal_q <= 1'b0;
			end
			lo_q   <= lo_q + AW'(1);
			hi_q   <= hi_q - AW'(1);
			left_q <= left_q - CW'(1);
		end
	end

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe outside a busy period");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block not idle after result");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && end_of_line) |=> busy)
		else $error("last byte did not start the walk");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_LETTERS))
		else $error("letter count beyond capacity");

	a_ovf_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(done && store_overflow) |-> !is_palindrome)
		else $error("overflowed line reported as palindrome");
`endif

endmodule
